// ===== design/ba_pkg.sv =====
`timescale 1ns / 1ps

package ba_pkg;

    // default pool geometry
    localparam int DEF_TOTAL_UNITS = 1024;
    localparam int DEF_MIN_BLOCK   = 4;
    localparam int DEF_ORDER_COUNT = 9;

    // field widths
    localparam int SIZE_W   = 11;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 6;
    localparam int ORD_W    = 4;
    localparam int HEAD_IDX = 5;
    localparam int USED_IDX = 4;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_CLEAR = 4'd1,
        OP_LOAD  = 4'd2,
        OP_SCAN  = 4'd3,
        OP_SPLIT = 4'd4,
        OP_DIV   = 4'd5,
        OP_CHK   = 4'd6,
        OP_FCHK  = 4'd7,
        OP_MERGE = 4'd8,
        OP_MCHK  = 4'd9
    } t_op;

    // datapath status back to the controller
    typedef struct packed {
        logic clr_done;
        logic too_big;
        logic is_free;
        logic scan_done;
        logic found;
        logic split_done;
        logic chk_bad;
        logic fchk_bad;
        logic merge_stop;
        logic mchk_stop;
    } t_dp_status;

endpackage

// ===== design/ba_ctrl.sv =====
`timescale 1ns / 1ps

module ba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_done,
    input  ba_pkg::t_dp_status i_st,
    output ba_pkg::t_op       o_op
);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_SCAN  = 10'b00_0000_0100,
        S_SPLIT = 10'b00_0000_1000,
        S_DIV   = 10'b00_0001_0000,
        S_CHK   = 10'b00_0010_0000,
        S_FCHK  = 10'b00_0100_0000,
        S_MERGE = 10'b00_1000_0000,
        S_MCHK  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and operation select
    always_comb begin
        n_state = r_state;
        o_op    = ba_pkg::OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_op = ba_pkg::OP_CLEAR;
                if (i_st.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_op = ba_pkg::OP_LOAD;
                    if (i_st.is_free)      n_state = S_DIV;
                    else if (i_st.too_big) n_state = S_DONE;
                    else                   n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_op = ba_pkg::OP_SCAN;
                if (i_st.scan_done) n_state = i_st.found ? S_SPLIT : S_DONE;
            end
            S_SPLIT: begin
                o_op = ba_pkg::OP_SPLIT;
                if (i_st.split_done) n_state = S_DONE;
            end
            S_DIV: begin
                o_op    = ba_pkg::OP_DIV;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_op    = ba_pkg::OP_CHK;
                n_state = i_st.chk_bad ? S_DONE : S_FCHK;
            end
            S_FCHK: begin
                o_op    = ba_pkg::OP_FCHK;
                n_state = i_st.fchk_bad ? S_DONE : S_MERGE;
            end
            S_MERGE: begin
                o_op    = ba_pkg::OP_MERGE;
                n_state = i_st.merge_stop ? S_DONE : S_MCHK;
            end
            S_MCHK: begin
                o_op    = ba_pkg::OP_MCHK;
                n_state = i_st.mchk_stop ? S_DONE : S_MERGE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// ===== design/ba_dp.sv =====
`timescale 1ns / 1ps

module ba_dp #(
    parameter int TOTAL_UNITS = ba_pkg::DEF_TOTAL_UNITS,
    parameter int MIN_BLOCK   = ba_pkg::DEF_MIN_BLOCK,
    parameter int ORDER_COUNT = ba_pkg::DEF_ORDER_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ba_pkg::t_op                 i_op,
    input  logic                        i_command,
    input  logic [ba_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ba_pkg::ADDR_W-1:0]   i_block_address,
    output ba_pkg::t_dp_status          o_st,
    output logic [ba_pkg::STATUS_W-1:0] o_status,
    output logic [ba_pkg::ADDR_W-1:0]   o_result_address
);

    localparam int SLOT_COUNT = TOTAL_UNITS / MIN_BLOCK;
    localparam int SW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TOP        = ORDER_COUNT - 1;
    localparam int TOP_SLOTS  = 1 << TOP;
    localparam int XW         = ((SW > ORDER_COUNT) ? SW : ORDER_COUNT) + 1;
    localparam int OW         = ba_pkg::ORD_W;
    localparam int EW         = ba_pkg::ENTRY_W;
    localparam int AW         = ba_pkg::ADDR_W;
    localparam int DIV_SH     = 17;
    localparam int RECIP      = ((1 << DIV_SH) + MIN_BLOCK - 1) / MIN_BLOCK;
    localparam int QW         = AW + 1;

    // slot table
    logic [EW-1:0] r_mem [SLOT_COUNT];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [SW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    logic [XW-1:0]      r_cnt, n_cnt;
    logic               r_eval_vld, n_eval_vld;
    logic [XW-1:0]      r_eval_idx, n_eval_idx;
    logic [AW-1:0]      r_addr, n_addr;
    logic [OW-1:0]      r_want, n_want;
    logic               r_found, n_found;
    logic [XW-1:0]      r_best_s, n_best_s;
    logic [OW-1:0]      r_best_k, n_best_k;
    logic [OW-1:0]      r_cur, n_cur;
    logic [XW-1:0]      r_s, n_s;
    logic [XW-1:0]      r_b, n_b;
    logic [OW-1:0]      r_k, n_k;
    logic [QW-1:0]      r_q, n_q;
    logic [ba_pkg::STATUS_W-1:0] r_status, n_status;
    logic [AW-1:0]      r_res, n_res;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_eval_vld <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_eval_vld <= n_eval_vld;
            r_found    <= n_found;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_eval_idx <= n_eval_idx;
        r_addr     <= n_addr;
        r_want     <= n_want;
        r_best_s   <= n_best_s;
        r_best_k   <= n_best_k;
        r_cur      <= n_cur;
        r_s        <= n_s;
        r_b        <= n_b;
        r_k        <= n_k;
        r_q        <= n_q;
        r_status   <= n_status;
        r_res      <= n_res;
    end

    // rounding of the request to an order
    logic [OW:0] want_full;
    always_comb begin
        want_full = '0;
        for (int k = 0; k < ORDER_COUNT; k++) begin
            if ((32'(MIN_BLOCK) << k) < 32'(i_request_size)) want_full = want_full + 1'b1;
        end
    end

    logic [31:0]       cnt32, q32, b32, top_chk;
    logic [XW-1:0]     buddy;
    logic [OW-1:0]     cur_m1;
    logic [XW+6:0]     res_prod;
    logic [AW+17:0]    div_prod;
    logic              good, eval_hit;
    logic [OW-1:0]     e_ord;

    always_comb begin
        n_cnt      = r_cnt;
        n_eval_vld = r_eval_vld;
        n_eval_idx = r_eval_idx;
        n_addr     = r_addr;
        n_want     = r_want;
        n_found    = r_found;
        n_best_s   = r_best_s;
        n_best_k   = r_best_k;
        n_cur      = r_cur;
        n_s        = r_s;
        n_b        = r_b;
        n_k        = r_k;
        n_q        = r_q;
        n_status   = r_status;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_wa     = r_s[SW-1:0];
        mem_wd     = '0;
        mem_ra     = r_cnt[SW-1:0];
        o_st       = '0;

        cnt32    = 32'(r_cnt);
        q32      = 32'(r_q);
        top_chk  = cnt32 + 32'(TOP_SLOTS);
        cur_m1   = r_cur - 1'b1;
        buddy    = '0;
        b32      = '0;
        good     = 1'b0;
        eval_hit = 1'b0;
        e_ord    = r_rd[OW-1:0];
        res_prod = {7'd0, r_s} * (XW+7)'(MIN_BLOCK);
        div_prod = {18'd0, r_addr} * (AW+18)'(RECIP);

        o_st.too_big = (want_full >= (OW+1)'(ORDER_COUNT));
        o_st.is_free = (i_command == ba_pkg::CMD_FREE);
        o_st.found   = r_found;

        case (i_op)
            // sweep after reset: top blocks at their places, the rest empty
            ba_pkg::OP_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt[SW-1:0];
                if ((cnt32 & 32'(TOP_SLOTS - 1)) == 32'd0 && top_chk <= 32'(SLOT_COUNT))
                    mem_wd = {1'b1, 1'b0, OW'(TOP)};
                n_cnt = r_cnt + 1'b1;
                o_st.clr_done = (cnt32 == 32'(SLOT_COUNT - 1));
            end
            // capture a new transaction
            ba_pkg::OP_LOAD: begin
                n_addr     = i_block_address;
                n_want     = want_full[OW-1:0];
                n_cnt      = '0;
                n_eval_vld = 1'b0;
                n_found    = 1'b0;
                n_res      = '0;
                n_status   = (i_command == ba_pkg::CMD_FREE) ? ba_pkg::ST_BAD_ADDR
                                                              : ba_pkg::ST_NO_SPACE;
            end
            // pass over all slots, keep smallest sufficient order, lowest slot
            ba_pkg::OP_SCAN: begin
                n_eval_vld = (cnt32 < 32'(SLOT_COUNT));
                n_eval_idx = r_cnt;
                if (cnt32 < 32'(SLOT_COUNT)) n_cnt = r_cnt + 1'b1;
                if (r_eval_vld) begin
                    eval_hit = r_rd[ba_pkg::HEAD_IDX] && !r_rd[ba_pkg::USED_IDX] &&
                               (e_ord >= r_want) && (!r_found || e_ord < r_best_k);
                    if (eval_hit) begin
                        n_found  = 1'b1;
                        n_best_s = r_eval_idx;
                        n_best_k = e_ord;
                    end
                end
                o_st.scan_done = !(cnt32 < 32'(SLOT_COUNT)) && !r_eval_vld;
                n_cur = r_best_k;
                n_s   = r_best_s;
            end
            // split down, upper halves become free blocks
            ba_pkg::OP_SPLIT: begin
                if (r_cur > r_want) begin
                    buddy  = r_s + (XW'(1) << cur_m1);
                    b32    = 32'(buddy);
                    mem_wa = buddy[SW-1:0];
                    mem_wd = {1'b1, 1'b0, cur_m1};
                    mem_we = (b32 < 32'(SLOT_COUNT));
                    n_cur  = cur_m1;
                end else begin
                    mem_we   = 1'b1;
                    mem_wa   = r_s[SW-1:0];
                    mem_wd   = {1'b1, 1'b1, r_want};
                    n_status = ba_pkg::ST_OK;
                    n_res    = res_prod[AW-1:0];
                    o_st.split_done = 1'b1;
                end
            end
            // address to slot by reciprocal multiply
            ba_pkg::OP_DIV: begin
                n_q = div_prod[DIV_SH +: QW];
            end
            // exact multiple and inside the pool, then read the slot
            ba_pkg::OP_CHK: begin
                good   = ((q32 * 32'(MIN_BLOCK)) == 32'(r_addr)) && (q32 < 32'(SLOT_COUNT));
                mem_ra = q32[SW-1:0];
                n_s    = q32[XW-1:0];
                o_st.chk_bad = !good;
            end
            // slot must head a block in use
            ba_pkg::OP_FCHK: begin
                if (r_rd[ba_pkg::HEAD_IDX] && r_rd[ba_pkg::USED_IDX]) begin
                    n_k    = e_ord;
                    mem_we = 1'b1;
                    mem_wa = r_s[SW-1:0];
                    mem_wd = '0;
                end else begin
                    o_st.fchk_bad = 1'b1;
                end
            end
            // look up the buddy or close the merged block
            ba_pkg::OP_MERGE: begin
                buddy = r_s ^ (XW'(1) << r_k);
                b32   = 32'(buddy);
                if ((r_k < OW'(TOP)) && (b32 < 32'(SLOT_COUNT))) begin
                    mem_ra = buddy[SW-1:0];
                    n_b    = buddy;
                end else begin
                    mem_we   = 1'b1;
                    mem_wa   = r_s[SW-1:0];
                    mem_wd   = {1'b1, 1'b0, r_k};
                    n_status = ba_pkg::ST_OK;
                    o_st.merge_stop = 1'b1;
                end
            end
            // absorb a free buddy of the same order
            ba_pkg::OP_MCHK: begin
                if (r_rd[ba_pkg::HEAD_IDX] && !r_rd[ba_pkg::USED_IDX] && e_ord == r_k) begin
                    mem_we = 1'b1;
                    mem_wa = r_b[SW-1:0];
                    mem_wd = '0;
                    if (r_b < r_s) n_s = r_b;
                    n_k = r_k + 1'b1;
                end else begin
                    mem_we   = 1'b1;
                    mem_wa   = r_s[SW-1:0];
                    mem_wd   = {1'b1, 1'b0, r_k};
                    n_status = ba_pkg::ST_OK;
                    o_st.mchk_stop = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status         = r_status;
    assign o_result_address = r_res;

endmodule

// ===== design/buddy_allocator.sv =====
`timescale 1ns / 1ps

// Buddy allocator over a pool of TOTAL_UNITS units in blocks of MIN_BLOCK << k
// units. Pulse start while busy is low; the transaction is taken at that edge
// and busy stays high until the answer has been shown. The answer appears on
// o_status and o_result_address for exactly one cycle with o_done high and
// cannot be held off, so the receiver must take it in that cycle. After reset
// a clearing pass over all TOTAL_UNITS/MIN_BLOCK slots sets up the slot table, with
// busy high. An allocate scans every slot of the slot table, which has one read
// port, one slot a cycle, then splits the chosen block down one order per step. A
// free turns the address into a slot, checks it, then merges with free buddies of
// the same order up to at most the top order; a rejected request finishes sooner.

module buddy_allocator #(
    parameter int TOTAL_UNITS = ba_pkg::DEF_TOTAL_UNITS,
    parameter int MIN_BLOCK   = ba_pkg::DEF_MIN_BLOCK,
    parameter int ORDER_COUNT = ba_pkg::DEF_ORDER_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [ba_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ba_pkg::ADDR_W-1:0]   i_block_address,
    output logic                        o_done,
    output logic [ba_pkg::STATUS_W-1:0] o_status,
    output logic [ba_pkg::ADDR_W-1:0]   o_result_address
);

    ba_pkg::t_op        op;
    ba_pkg::t_dp_status st;

    // sequencer
    ba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_st    (st),
        .o_op    (op)
    );

    // slot table and working registers
    ba_dp #(
        .TOTAL_UNITS (TOTAL_UNITS),
        .MIN_BLOCK   (MIN_BLOCK),
        .ORDER_COUNT (ORDER_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_command        (i_command),
        .i_request_size   (i_request_size),
        .i_block_address  (i_block_address),
        .o_st             (st),
        .o_status         (o_status),
        .o_result_address (o_result_address)
    );

endmodule
